@@ rtl/txc_pkg.sv @@
// Shared constants, types and the store command for the text console writer.
`timescale 1ns / 1ps

package txc_pkg;

  // Screen geometry.
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int ADDR_W     = ROW_W + COL_W;

  // Field widths.
  localparam int KIND_W = 1;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int LOC_W  = 11;
  localparam int CELL_W = ATTR_W + CHAR_W;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_PUT  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

  // Reciprocal of the column count for splitting a linear index into row and column.
  // The quotient estimate is never low and at most one too high.
  localparam int RECIP_SH = 16;
  localparam int RECIP    = ((2 ** RECIP_SH) + COLUMNS - 1) / COLUMNS;
  localparam int RECIP_W  = $clog2(RECIP + 1);

  // Request from the control logic to the cell store.
  typedef struct packed {
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [COL_W-1:0]  wr_col;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  rd_col;
    logic              fill_en;
    logic [ROW_W-1:0]  fill_row;
    logic [CELL_W-1:0] fill_data;
  } txc_store_cmd_t;

endpackage

@@ rtl/txc_cfg_if.sv @@
// Configuration write channel carrying the text attribute.
`timescale 1ns / 1ps

interface txc_cfg_if
  import txc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] text_attribute;

  modport source (output valid, output text_attribute, input ready);
  modport sink   (input valid, input text_attribute, output ready);
endinterface

@@ rtl/txc_item_if.sv @@
// Request channel carrying put and read items.
`timescale 1ns / 1ps

interface txc_item_if
  import txc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, output kind, output char_code, output cell_index, input ready);
  modport sink   (input valid, input kind, input char_code, input cell_index, output ready);
endinterface

@@ rtl/txc_result_if.sv @@
// Result channel carrying the cursor location, a read cell and the scroll flag.
`timescale 1ns / 1ps

interface txc_result_if
  import txc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LOC_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;

  modport source (output valid, output cursor_pos, output cell_data, output scrolled,
                  input ready);
  modport sink   (input valid, input cursor_pos, input cell_data, input scrolled,
                  output ready);
endinterface

@@ rtl/txc_cell_store.sv @@
// Cell memory with a row fill sequencer and the clearing pass after reset.
`timescale 1ns / 1ps

module txc_cell_store
  import txc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  txc_store_cmd_t    cmd_i,
  output logic [CELL_W-1:0] rd_data_o,
  output logic              busy_o
);

  logic [CELL_W-1:0] mem_q [2 ** ADDR_W];
  logic [CELL_W-1:0] rd_data_q;

  // Sweep engine: clears every row after reset, or one row on a scroll.
  logic              sweep_q, sweep_d;
  logic              sweep_all_q, sweep_all_d;
  logic [ROW_W-1:0]  sweep_row_q, sweep_row_d;
  logic [COL_W-1:0]  sweep_col_q, sweep_col_d;
  logic [CELL_W-1:0] fill_data_q, fill_data_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;

  always_comb begin
    sweep_d     = sweep_q;
    sweep_all_d = sweep_all_q;
    sweep_row_d = sweep_row_q;
    sweep_col_d = sweep_col_q;
    fill_data_d = fill_data_q;
    if (sweep_q) begin
      if (sweep_col_q == COL_W'(COLUMNS - 1)) begin
        sweep_col_d = '0;
        if (sweep_all_q && (sweep_row_q != ROW_W'(ROWS - 1))) begin
          sweep_row_d = sweep_row_q + 1'b1;
        end else begin
          sweep_d     = 1'b0;
          sweep_all_d = 1'b0;
        end
      end else begin
        sweep_col_d = sweep_col_q + 1'b1;
      end
    end else if (cmd_i.fill_en) begin
      sweep_d     = 1'b1;
      sweep_all_d = 1'b0;
      sweep_row_d = cmd_i.fill_row;
      sweep_col_d = '0;
      fill_data_d = cmd_i.fill_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_all_q <= 1'b1;
      sweep_row_q <= '0;
      sweep_col_q <= '0;
    end else begin
      sweep_q     <= sweep_d;
      sweep_all_q <= sweep_all_d;
      sweep_row_q <= sweep_row_d;
      sweep_col_q <= sweep_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_data_q <= fill_data_d;
  end

  always_comb begin
    if (sweep_q) begin
      we    = 1'b1;
      waddr = {sweep_row_q, sweep_col_q};
      wdata = sweep_all_q ? BLANK_RESET : fill_data_q;
    end else begin
      we    = cmd_i.wr_en;
      waddr = {cmd_i.wr_row, cmd_i.wr_col};
      wdata = cmd_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[{cmd_i.rd_row, cmd_i.rd_col}];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = sweep_q;

endmodule

@@ rtl/text_console_writer.sv @@
// Top level of the text console writer: cursor control, index split and result register.
// A put passes through S_DONE and a read through S_LOOK, S_DATA and S_DONE to its result.
// A put that scrolls first waits in S_FILL until the row fill of COLUMNS cells has ended.
// One item is handled at a time; the next request is taken once the result is registered.
// Reset clears the cursor and the row offset and sets the attribute to 0x0F; a clearing
// pass then writes blanks to all COLUMNS*ROWS cells with requests held off.
`timescale 1ns / 1ps

module text_console_writer
  import txc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  txc_cfg_if.sink    cfg_i,
  txc_item_if.sink   item_i,
  txc_result_if.source result_o
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_DATA = 3'd2;
  localparam logic [2:0] S_FILL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam int QP_W   = IDX_W + RECIP_W;
  localparam int PROD_W = IDX_W + COL_W + 1;

  // Maps a logical row onto a physical memory row. The screen scrolls by moving the
  // top row offset instead of copying cells, so only the new bottom row is rewritten.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  logic [2:0]        state_q, state_d;
  logic [ATTR_W-1:0] attr_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  top_q, top_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  quo_q, quo_d;
  logic              in_range_q, in_range_d;
  logic              scroll_q, scroll_d;
  logic [CELL_W-1:0] cell_q, cell_d;

  logic              out_valid_q, out_valid_d;
  logic [LOC_W-1:0]  out_loc_q, out_loc_d;
  logic [CELL_W-1:0] out_cell_q, out_cell_d;
  logic              out_scroll_q, out_scroll_d;

  txc_store_cmd_t    store_cmd;
  logic [CELL_W-1:0] store_rd_data;
  logic              store_busy;

  logic              item_acc;
  logic              out_free;

  // Put decode.
  logic              printable;
  logic [COL_W:0]    put_col;
  logic [ROW_W:0]    put_row;
  logic              put_scroll;
  logic [ROW_W-1:0]  top_next;

  // Read index split.
  logic [QP_W-1:0]   quo_prod;
  logic [PROD_W-1:0] back_prod;
  logic [PROD_W-1:0] idx_ext;
  logic [IDX_W-1:0]  quo_fix;
  logic [PROD_W-1:0] rem_fix;

  logic [31:0]       loc_full;

  txc_cell_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (store_cmd),
    .rd_data_o (store_rd_data),
    .busy_o    (store_busy)
  );

  // Configuration writes must arrive only while idle; the block does not enforce this, ready is always high.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      attr_q <= cfg_i.text_attribute;
    end
  end

  // A new request is taken only while the sequencer is idle and no row sweep is running.
  // The result register is not checked here: a finished result may still wait downstream.
  assign item_i.ready = (state_q == S_IDLE) && !store_busy;
  assign item_acc     = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  // Cursor movement for a put, in the order the console defines: carriage return,
  // line feed or printable advance, then column wrap, then scroll at the bottom.
  always_comb begin
    printable = (item_i.char_code >= CH_SPACE);
    put_col   = {1'b0, col_q};
    put_row   = {1'b0, row_q};
    if (item_i.char_code == CH_CR) begin
      put_col = '0;
    end else if (item_i.char_code == CH_LF) begin
      put_row = put_row + 1'b1;
    end else if (printable) begin
      put_col = put_col + 1'b1;
    end
    if (put_col >= (COL_W + 1)'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    put_scroll = (put_row >= (ROW_W + 1)'(ROWS));
    if (put_scroll) begin
      put_row = (ROW_W + 1)'(ROWS - 1);
    end
    top_next = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
  end

  // First half of the index split: quotient estimate by reciprocal, registered.
  assign quo_prod = QP_W'(item_i.cell_index) * QP_W'(RECIP);

  // Second half: multiply back, correct an estimate that came out one too high.
  always_comb begin
    idx_ext   = PROD_W'(idx_q);
    back_prod = PROD_W'(quo_q) * PROD_W'(COLUMNS);
    if (back_prod > idx_ext) begin
      quo_fix = quo_q - 1'b1;
      rem_fix = idx_ext + PROD_W'(COLUMNS) - back_prod;
    end else begin
      quo_fix = quo_q;
      rem_fix = idx_ext - back_prod;
    end
  end

  assign loc_full = 32'(row_q) * 32'(COLUMNS) + 32'(col_q);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    top_d        = top_q;
    idx_d        = idx_q;
    quo_d        = quo_q;
    in_range_d   = in_range_q;
    scroll_d     = scroll_q;
    cell_d       = cell_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_loc_d    = out_loc_q;
    out_cell_d   = out_cell_q;
    out_scroll_d = out_scroll_q;

    store_cmd           = '0;
    store_cmd.wr_row    = phys_row(row_q, top_q);
    store_cmd.wr_col    = col_q;
    store_cmd.wr_data   = {attr_q, item_i.char_code};
    store_cmd.rd_row    = phys_row(quo_fix[ROW_W-1:0], top_q);
    store_cmd.rd_col    = rem_fix[COL_W-1:0];
    store_cmd.fill_row  = top_q;
    store_cmd.fill_data = {attr_q, CH_SPACE};

    unique case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          if (item_i.kind == KIND_READ) begin
            idx_d      = item_i.cell_index;
            quo_d      = IDX_W'(quo_prod >> RECIP_SH);
            in_range_d = (32'(item_i.cell_index) < 32'(CELL_COUNT));
            scroll_d   = 1'b0;
            state_d    = S_LOOK;
          end else begin
            // The character lands at the cursor before it moves; the cursor is
            // always inside the screen, so no bound check is needed.
            store_cmd.wr_en = printable;
            col_d           = put_col[COL_W-1:0];
            row_d           = put_row[ROW_W-1:0];
            scroll_d        = put_scroll;
            cell_d          = '0;
            if (put_scroll) begin
              // The old top row becomes the bottom row and is filled with blanks.
              store_cmd.fill_en = 1'b1;
              top_d             = top_next;
              state_d           = S_FILL;
            end else begin
              state_d = S_DONE;
            end
          end
        end
      end
      S_LOOK: begin
        store_cmd.rd_en = in_range_q;
        state_d         = S_DATA;
      end
      S_DATA: begin
        cell_d  = in_range_q ? store_rd_data : '0;
        state_d = S_DONE;
      end
      S_FILL: begin
        if (!store_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_loc_d    = loc_full[LOC_W-1:0];
          out_cell_d   = cell_q;
          out_scroll_d = scroll_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    quo_q        <= quo_d;
    in_range_q   <= in_range_d;
    scroll_q     <= scroll_d;
    cell_q       <= cell_d;
    out_loc_q    <= out_loc_d;
    out_cell_q   <= out_cell_d;
    out_scroll_q <= out_scroll_d;
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.cursor_pos = out_loc_q;
  assign result_o.cell_data  = out_cell_q;
  assign result_o.scrolled   = out_scroll_q;

`ifndef SYNTH
  // The cursor and the row offset never leave the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < 32'(COLUMNS)) && (32'(row_q) < 32'(ROWS)) && (32'(top_q) < 32'(ROWS)))
    else $error("cursor or row offset outside the screen");

  // A scrolling put must start the bottom row fill.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_acc && (item_i.kind == KIND_PUT) && put_scroll) |=> (store_busy && (state_q == S_FILL)))
    else $error("scroll did not start a row fill");

  // A result is only produced once the fill has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> !store_busy)
    else $error("result released during a row sweep");

  // A read keeps the cursor where it was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_acc && (item_i.kind == KIND_READ)) |=> ($stable(col_q) && $stable(row_q)))
    else $error("read moved the cursor");
`endif

endmodule
